// ===== hdl/jcb_pkg.sv =====
// Package for the JSON comment blanker: beat types, queue entry type,
// character and scan-mode constants. No dependencies.
package jcb_pkg;

    localparam int QueueDepthDef = 2;

    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChStar   = 8'h2A;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChSpace  = 8'h20;

    localparam logic [2:0] ModeNormal    = 3'd0;
    localparam logic [2:0] ModeString    = 3'd1;
    localparam logic [2:0] ModeStringEsc = 3'd2;
    localparam logic [2:0] ModeSlash     = 3'd3;
    localparam logic [2:0] ModeLine      = 3'd4;
    localparam logic [2:0] ModeBlock     = 3'd5;
    localparam logic [2:0] ModeBlockStar = 3'd6;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       unterminated;
    } out_beat_t;

    // One classified input byte: one or two result bytes; last and
    // unterminated belong to the final one.
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       last;
        logic       unterm;
    } op_t;

endpackage

// ===== hdl/jcb_front.sv =====
// Front end of the JSON comment blanker: accepts input beats, tracks the scan mode and
// classifies bytes into queue entries; a held slash joins the next byte's entry. Uses jcb_pkg.
module jcb_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  jcb_pkg::in_beat_t in_data,
    input  logic             q_full,
    output logic             q_push,
    output jcb_pkg::op_t     q_op
);

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic [2:0] scan_next;
    logic [1:0] n_res;
    logic       accept;
    logic [7:0] b;
    logic       is_eol;

    assign b        = in_data.in_byte;
    assign is_eol   = (b == jcb_pkg::ChLf) || (b == jcb_pkg::ChCr);
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        scan_next      = mode_reg;
        n_res          = 2'd1;
        q_op.two       = 1'b0;
        q_op.byte0     = b;
        q_op.byte1     = b;
        q_op.last      = in_data.in_last;
        q_op.unterm    = 1'b0;
        case (mode_reg)
            jcb_pkg::ModeString:
            begin
                if (b == jcb_pkg::ChBslash)
                    scan_next = jcb_pkg::ModeStringEsc;
                else if (b == jcb_pkg::ChQuote)
                    scan_next = jcb_pkg::ModeNormal;
            end
            jcb_pkg::ModeStringEsc:
            begin
                scan_next = jcb_pkg::ModeString;
            end
            jcb_pkg::ModeSlash:
            begin
                n_res    = 2'd2;
                q_op.two = 1'b1;
                if (b == jcb_pkg::ChSlash)
                begin
                    q_op.byte0 = jcb_pkg::ChSpace;
                    q_op.byte1 = jcb_pkg::ChSpace;
                    scan_next  = jcb_pkg::ModeLine;
                end
                else if (b == jcb_pkg::ChStar)
                begin
                    q_op.byte0  = jcb_pkg::ChSpace;
                    q_op.byte1  = jcb_pkg::ChSpace;
                    q_op.unterm = in_data.in_last;
                    scan_next   = jcb_pkg::ModeBlock;
                end
                else
                begin
                    q_op.byte0 = jcb_pkg::ChSlash;
                    scan_next  = (b == jcb_pkg::ChQuote) ? jcb_pkg::ModeString
                                                         : jcb_pkg::ModeNormal;
                end
            end
            jcb_pkg::ModeLine:
            begin
                if (is_eol)
                    scan_next = jcb_pkg::ModeNormal;
                else
                    q_op.byte0 = jcb_pkg::ChSpace;
            end
            jcb_pkg::ModeBlock, jcb_pkg::ModeBlockStar:
            begin
                if (mode_reg == jcb_pkg::ModeBlockStar && b == jcb_pkg::ChSlash)
                begin
                    q_op.byte0 = jcb_pkg::ChSpace;
                    scan_next  = jcb_pkg::ModeNormal;
                end
                else
                begin
                    if (!is_eol)
                        q_op.byte0 = jcb_pkg::ChSpace;
                    q_op.unterm = in_data.in_last;
                    scan_next   = (b == jcb_pkg::ChStar) ? jcb_pkg::ModeBlockStar
                                                         : jcb_pkg::ModeBlock;
                end
            end
            default:
            begin
                if (b == jcb_pkg::ChQuote)
                    scan_next = jcb_pkg::ModeString;
                else if (b == jcb_pkg::ChSlash && !in_data.in_last)
                begin
                    n_res     = 2'd0;
                    scan_next = jcb_pkg::ModeSlash;
                end
                else
                    scan_next = jcb_pkg::ModeNormal;
            end
        endcase
        mode_next = in_data.in_last ? jcb_pkg::ModeNormal : scan_next;
    end

    assign q_push = accept && (n_res != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= jcb_pkg::ModeNormal;
        else if (accept)
            mode_reg <= mode_next;
    end

endmodule

// ===== hdl/jcb_queue.sv =====
// Short queue of classified bytes between front and back of the JSON
// comment blanker. Uses jcb_pkg.
module jcb_queue
#(
    parameter int DEPTH = jcb_pkg::QueueDepthDef
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  jcb_pkg::op_t push_op,
    input  logic         pop,
    output jcb_pkg::op_t head_op,
    output logic         full,
    output logic         empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jcb_pkg::op_t   mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
    end

endmodule

// ===== hdl/jcb_back.sv =====
// Back end of the JSON comment blanker: drains the queue one result beat
// per cycle, while out_ready does not stall it, into the output register. Uses jcb_pkg.
module jcb_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  jcb_pkg::op_t       head_op,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output jcb_pkg::out_beat_t out_data
);

    logic               out_valid_reg;
    logic               out_valid_next;
    jcb_pkg::out_beat_t out_data_reg;
    jcb_pkg::out_beat_t out_data_next;
    logic               phase_reg;
    logic               phase_next;
    logic               load;
    logic               first_of_two;

    assign load         = !out_valid_reg || out_ready;
    assign first_of_two = head_op.two && !phase_reg;
    assign q_pop        = load && !q_empty && !first_of_two;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        phase_next     = phase_reg;
        if (load)
        begin
            out_valid_next = !q_empty;
            if (!q_empty)
            begin
                if (first_of_two)
                begin
                    out_data_next.out_byte     = head_op.byte0;
                    out_data_next.out_last     = 1'b0;
                    out_data_next.unterminated = 1'b0;
                    phase_next                 = 1'b1;
                end
                else
                begin
                    out_data_next.out_byte     = head_op.two ? head_op.byte1 : head_op.byte0;
                    out_data_next.out_last     = head_op.last;
                    out_data_next.unterminated = head_op.unterm;
                    phase_next                 = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/json_comment_blanker_top.sv =====
// JSON comment blanker top level. An accepted input beat is classified into the queue,
// then the back end loads its result beat into the output register.
// Throughput: one byte per cycle while the queue is not full; a byte that releases a held
// slash gives two beats, which leave the single output register one after the other.
// Reset (rst_n low, asynchronous): scan mode to normal, queue empty, no output.
// Depends on jcb_pkg, jcb_front, jcb_queue, jcb_back.
module json_comment_blanker_top
#(
    parameter int QUEUE_DEPTH = jcb_pkg::QueueDepthDef
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  jcb_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output jcb_pkg::out_beat_t out_data
);

    jcb_pkg::op_t push_op;
    jcb_pkg::op_t head_op;
    logic         q_push;
    logic         q_pop;
    logic         q_full;
    logic         q_empty;

    jcb_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    jcb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    jcb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head_op   (head_op),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/jcb_checker.sv =====
// Port-level checker for the JSON comment blanker, bound to the top level.
// Uses jcb_pkg.
module jcb_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input jcb_pkg::in_beat_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input jcb_pkg::out_beat_t out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    a_unterm_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.unterminated |-> out_data.out_last)
        else $error("unterminated flag without last");

    a_unterm_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.unterminated |->
            (out_data.out_byte == jcb_pkg::ChSpace) ||
            (out_data.out_byte == jcb_pkg::ChLf) ||
            (out_data.out_byte == jcb_pkg::ChCr))
        else $error("unterminated beat carries a non-blank byte");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid straight after reset");

endmodule

bind json_comment_blanker_top jcb_checker u_jcb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== verif/jcb_blank_monitor.sv =====
// Monitor for the JSON comment blanker: watches both channels, predicts the
// blanked text from accepted input beats and compares every output beat.
// Depends on jcb_pkg.
module jcb_blank_monitor
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  jcb_pkg::in_beat_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  jcb_pkg::out_beat_t out_data,
    output int                 errors,
    output int                 pending
);

    logic [2:0]         scan_mode;
    jcb_pkg::out_beat_t blanked_q[$];

    function automatic void note_error(input string what, input jcb_pkg::out_beat_t want,
                                       input jcb_pkg::out_beat_t got);
        errors++;
        if (errors <= 10)
        begin
            $display("%0t %s: expected byte %02h last %0b unterm %0b,",
                     $realtime, what, want.out_byte, want.out_last, want.unterminated,
                     " got byte %02h last %0b unterm %0b",
                     got.out_byte, got.out_last, got.unterminated);
        end
    endfunction

    function automatic void blank_beat(input jcb_pkg::in_beat_t beat);
        logic [7:0]         ch;
        logic [2:0]         next_mode;
        logic               unterm;
        jcb_pkg::out_beat_t res [2];
        int                 n;
        ch        = beat.in_byte;
        next_mode = scan_mode;
        unterm    = 1'b0;
        n         = 0;
        case (scan_mode)
            jcb_pkg::ModeString:
            begin
                res[0] = {ch, 2'b00};
                n = 1;
                if (ch == jcb_pkg::ChBslash)
                    next_mode = jcb_pkg::ModeStringEsc;
                else if (ch == jcb_pkg::ChQuote)
                    next_mode = jcb_pkg::ModeNormal;
            end
            jcb_pkg::ModeStringEsc:
            begin
                res[0] = {ch, 2'b00};
                n = 1;
                next_mode = jcb_pkg::ModeString;
            end
            jcb_pkg::ModeSlash:
            begin
                n = 2;
                if (ch == jcb_pkg::ChSlash)
                begin
                    res[0] = {jcb_pkg::ChSpace, 2'b00};
                    res[1] = {jcb_pkg::ChSpace, 2'b00};
                    next_mode = jcb_pkg::ModeLine;
                end
                else if (ch == jcb_pkg::ChStar)
                begin
                    res[0] = {jcb_pkg::ChSpace, 2'b00};
                    res[1] = {jcb_pkg::ChSpace, 2'b00};
                    next_mode = jcb_pkg::ModeBlock;
                    unterm = 1'b1;
                end
                else
                begin
                    res[0] = {jcb_pkg::ChSlash, 2'b00};
                    res[1] = {ch, 2'b00};
                    next_mode = (ch == jcb_pkg::ChQuote) ? jcb_pkg::ModeString
                                                         : jcb_pkg::ModeNormal;
                end
            end
            jcb_pkg::ModeLine:
            begin
                n = 1;
                if (ch == jcb_pkg::ChLf || ch == jcb_pkg::ChCr)
                begin
                    res[0] = {ch, 2'b00};
                    next_mode = jcb_pkg::ModeNormal;
                end
                else
                    res[0] = {jcb_pkg::ChSpace, 2'b00};
            end
            jcb_pkg::ModeBlock, jcb_pkg::ModeBlockStar:
            begin
                n = 1;
                if (scan_mode == jcb_pkg::ModeBlockStar && ch == jcb_pkg::ChSlash)
                begin
                    res[0] = {jcb_pkg::ChSpace, 2'b00};
                    next_mode = jcb_pkg::ModeNormal;
                end
                else
                begin
                    res[0] = {(ch == jcb_pkg::ChLf || ch == jcb_pkg::ChCr) ? ch
                                                                           : jcb_pkg::ChSpace,
                              2'b00};
                    next_mode = (ch == jcb_pkg::ChStar) ? jcb_pkg::ModeBlockStar
                                                        : jcb_pkg::ModeBlock;
                    unterm = 1'b1;
                end
            end
            default:
            begin
                if (ch == jcb_pkg::ChSlash && !beat.in_last)
                    next_mode = jcb_pkg::ModeSlash;
                else
                begin
                    res[0] = {ch, 2'b00};
                    n = 1;
                    next_mode = (ch == jcb_pkg::ChQuote) ? jcb_pkg::ModeString
                                                         : jcb_pkg::ModeNormal;
                end
            end
        endcase
        if (beat.in_last)
        begin
            if (n > 0)
            begin
                res[n - 1].out_last     = 1'b1;
                res[n - 1].unterminated = unterm;
            end
            next_mode = jcb_pkg::ModeNormal;
        end
        for (int i = 0; i < n; i++)
            blanked_q.push_back(res[i]);
        scan_mode = next_mode;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode = jcb_pkg::ModeNormal;
            blanked_q.delete();
            errors    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (blanked_q.size() == 0)
                    note_error("unexpected beat", '0, out_data);
                else
                begin
                    jcb_pkg::out_beat_t want;
                    want = blanked_q.pop_front();
                    if (out_data.out_byte !== want.out_byte
                        || out_data.out_last !== want.out_last
                        || out_data.unterminated !== want.unterminated)
                        note_error("mismatch", want, out_data);
                end
            end
            if (in_valid && in_ready)
                blank_beat(in_data);
        end
        pending = blanked_q.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the JSON comment blanker: drives JSON-like texts with
// comments, strings and noise under varying back-pressure, gives the verdict.
// Depends on jcb_pkg, json_comment_blanker_top and jcb_blank_monitor.
module tb;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    jcb_pkg::in_beat_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    jcb_pkg::out_beat_t out_data;
    int                 errors;
    int                 pending;

    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         hold_cycles = 0;
    int         items_sent  = 0;
    logic [7:0] text_q[$];

    json_comment_blanker_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    jcb_blank_monitor u_blank_mon
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic add_random(input int lo, input int hi);
        int len;
        len = $urandom_range(hi, lo);
        for (int i = 0; i < len; i++)
            text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_text();
        int nseg;
        int kind;
        int len;
        logic [7:0] ch;
        text_q.delete();
        if ($urandom_range(0, 99) < 15)
        begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 7))
                    0: ch = jcb_pkg::ChQuote;
                    1: ch = jcb_pkg::ChBslash;
                    2: ch = jcb_pkg::ChSlash;
                    3: ch = jcb_pkg::ChStar;
                    4: ch = jcb_pkg::ChLf;
                    5: ch = jcb_pkg::ChCr;
                    default: ch = 8'($urandom_range(0, 255));
                endcase
                text_q.push_back(ch);
            end
            return;
        end
        nseg = $urandom_range(1, 5);
        for (int s = 0; s < nseg; s++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 2)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    text_q.push_back(8'($urandom_range(8'h30, 8'h7A)));
            end
            else if (kind <= 4)
            begin
                text_q.push_back(jcb_pkg::ChQuote);
                len = $urandom_range(0, 6);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        text_q.push_back(jcb_pkg::ChBslash);
                        text_q.push_back(8'($urandom_range(0, 255)));
                    end
                    else
                    begin
                        ch = 8'($urandom_range(0, 255));
                        if (ch == jcb_pkg::ChQuote || ch == jcb_pkg::ChBslash)
                            ch = jcb_pkg::ChSlash;
                        text_q.push_back(ch);
                    end
                end
                if ($urandom_range(0, 4) != 0)
                    text_q.push_back(jcb_pkg::ChQuote);
            end
            else if (kind <= 6)
            begin
                add_str("//");
                add_random(0, 6);
                text_q.push_back($urandom_range(0, 1) ? jcb_pkg::ChLf : jcb_pkg::ChCr);
            end
            else if (kind <= 8)
            begin
                add_str("/*");
                len = $urandom_range(0, 6);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 3))
                        0: text_q.push_back(jcb_pkg::ChStar);
                        1: text_q.push_back(jcb_pkg::ChSlash);
                        default: text_q.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                if ($urandom_range(0, 6) != 0)
                    add_str("*/");
            end
            else
            begin
                text_q.push_back(jcb_pkg::ChSlash);
                add_random(1, 1);
            end
        end
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
        begin
            while ($urandom_range(0, 99) < tx_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= {text_q[i], i == text_q.size() - 1};
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            items_sent++;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        text_q.delete();
        add_str("\"/\\\"x\"/");
        send_text();
        text_q.delete();
        add_str("//a");
        text_q.push_back(jcb_pkg::ChCr);
        add_str("/*");
        text_q.push_back(jcb_pkg::ChLf);
        add_str("**//\"z");
        send_text();
        text_q.delete();
        add_str("/*");
        send_text();
        text_q.delete();
        add_str("//");
        send_text();
        text_q.delete();
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        send_text();

        items_sent = 0;
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    tx_idle_pct = 12;
                    rx_idle_pct = 83;
                end
                1:
                begin
                    tx_idle_pct = 83;
                    rx_idle_pct = 12;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_cycles = 300;
                end
            endcase
            while (items_sent < (p + 1) * 240)
            begin
                build_text();
                send_text();
            end
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/jcb_pkg.sv
hdl/jcb_front.sv
hdl/jcb_queue.sv
hdl/jcb_back.sv
hdl/json_comment_blanker_top.sv
hdl/jcb_checker.sv
verif/jcb_blank_monitor.sv
verif/tb.sv
